// File: sv/wcp_pkg.sv
`default_nettype none
package wcp_pkg;

  localparam int MAX_WINDOW_DEF = 5;
  localparam int IDX_W          = 4;   // ring index, token count and offsets up to 2*5+1
  localparam int WIN_W          = 3;
  localparam int TOK_W          = 64;  // {date, term}
  localparam int QDEPTH         = 2;
  localparam int PAIR_W         = 2 * TOK_W + 1;

  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(5);

  localparam logic OP_TOKEN = 1'b0;
  localparam logic OP_EOS   = 1'b1;

  typedef struct packed {
    logic             wr;
    logic             has;
    logic             multi;
    logic [TOK_W-1:0] tok;
    logic [IDX_W-1:0] newest;
    logic [IDX_W-1:0] c0;
    logic [IDX_W-1:0] n;
    logic [WIN_W-1:0] d;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage
`default_nettype wire

// File: sv/wcp_ram.sv
`default_nettype none
module wcp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: sv/wcp_fifo.sv
`default_nettype none
module wcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: sv/wcp_front.sv
`default_nettype none
module wcp_front
  import wcp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [WIN_W-1:0] cfg_wr_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,
  input  wire logic [TOK_W-1:0] in_tdata,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  wire logic             q_full
);

  localparam int RING_DEPTH = 2 * MAX_WINDOW + 1;

  logic [WIN_W-1:0] window_r;
  logic [IDX_W-1:0] seen_r, seen_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;

  logic             acc;
  logic             is_tok;
  logic [WIN_W-1:0] d;
  logic [IDX_W-1:0] d_ext;
  logic [IDX_W-1:0] n_tok;
  logic [IDX_W-1:0] pend;
  logic [IDX_W-1:0] head_prev;
  logic             has_tok;
  logic             has_eos;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign is_tok    = (in_tuser == OP_TOKEN);

  assign d     = (window_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_r;
  assign d_ext = IDX_W'(d);

  assign n_tok     = (seen_r < IDX_W'(RING_DEPTH)) ? seen_r + IDX_W'(1) : seen_r;
  assign pend      = (seen_r < d_ext) ? seen_r : d_ext;
  assign head_prev = (head_r == '0) ? IDX_W'(RING_DEPTH - 1) : head_r - IDX_W'(1);

  assign has_tok = (n_tok > d_ext) && (d_ext != '0);
  assign has_eos = (seen_r >= IDX_W'(2)) && (d_ext != '0);

  always_comb begin
    q_cmd.wr     = is_tok;
    q_cmd.has    = is_tok ? has_tok : has_eos;
    q_cmd.multi  = !is_tok;
    q_cmd.tok    = in_tdata;
    q_cmd.newest = is_tok ? head_r : head_prev;
    q_cmd.c0     = is_tok ? d_ext : pend - IDX_W'(1);
    q_cmd.n      = is_tok ? n_tok : seen_r;
    q_cmd.d      = d;
  end

  // end-of-sentence without pairs is absorbed here
  assign q_push = acc && (is_tok || has_eos);

  always_comb begin
    seen_nxt = seen_r;
    head_nxt = head_r;
    if (acc) begin
      if (is_tok) begin
        seen_nxt = n_tok;
        head_nxt = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
      end else begin
        seen_nxt = '0;
        head_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      seen_r   <= '0;
      head_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      seen_r <= seen_nxt;
      head_r <= head_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/wcp_back.sv
`default_nettype none
module wcp_back
  import wcp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire cmd_t                  q_cmd,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [2*TOK_W-1:0]    out_tdata,
  output logic                       out_tlast
);

  localparam int RING_DEPTH = 2 * MAX_WINDOW + 1;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int OCW        = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CTR  = 3'b010,
    S_NBR  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] d_r, d_nxt;
  logic [IDX_W-1:0] newest_r, newest_nxt;
  logic             multi_r, multi_nxt;
  logic [TOK_W-1:0] centre_r;
  logic             rd_vld_r, rd_ctr_r, rd_last_r;

  logic [TOK_W-1:0] ram_rdata;
  logic [IDX_W-1:0] rd_back;
  logic [IDX_W:0]   rd_wrap;
  logic [IDX_W-1:0] rd_idx;

  logic [IDX_W-1:0] left_room;
  logic [IDX_W-1:0] nl;
  logic [IDX_W-1:0] j0;
  logic [IDX_W-1:0] j_dec;
  logic [IDX_W-1:0] nj;
  logic             end_ctr;
  logic             last_item;

  logic [OCW-1:0]   ocnt;
  logic [OCW:0]     occ;
  logic             o_empty;
  logic             o_pop;
  logic             o_push;
  logic [PAIR_W-1:0] o_wdata;
  logic [PAIR_W-1:0] o_rdata;
  logic             issue_ok;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // ring address of the token rd_back places behind the newest one
  assign rd_back = (state_r == S_CTR) ? c_r : j_r;
  assign rd_wrap = {1'b0, newest_r} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, rd_back};
  assign rd_idx  = (rd_back > newest_r) ? rd_wrap[IDX_W-1:0] : newest_r - rd_back;

  wcp_ram #(
    .WIDTH (TOK_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (q_pop && q_cmd.wr),
    .waddr (q_cmd.newest[AW-1:0]),
    .wdata (q_cmd.tok),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign left_room = n_r - IDX_W'(1) - c_r;
  assign nl        = (left_room < d_r) ? left_room : d_r;
  assign j0        = (nl == '0) ? c_r - IDX_W'(1) : c_r + nl;

  // neighbour offsets descend to zero, skipping the centre itself
  assign j_dec     = j_r - IDX_W'(1);
  assign end_ctr   = (j_r == '0) || ((j_dec == c_r) && (c_r == '0));
  assign nj        = (j_dec == c_r) ? c_r - IDX_W'(1) : j_dec;
  assign last_item = end_ctr && (!multi_r || (c_r == '0));

  // credit: pairs queued plus neighbour read in flight
  assign o_pop    = out_tvalid && out_tready;
  assign occ      = {1'b0, ocnt} + (OCW + 1)'(rd_vld_r && !rd_ctr_r);
  assign issue_ok = (occ < (OCW + 1)'(QDEPTH)) || ((occ == (OCW + 1)'(QDEPTH)) && o_pop);

  assign o_push  = rd_vld_r && !rd_ctr_r;
  assign o_wdata = {rd_last_r, ram_rdata, centre_r};

  wcp_fifo #(
    .WIDTH (PAIR_W),
    .DEPTH (QDEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_wdata),
    .pop   (o_pop),
    .rdata (o_rdata),
    .empty (o_empty),
    .count (ocnt)
  );

  assign out_tvalid = !o_empty;
  assign out_tdata  = o_rdata[2*TOK_W-1:0];
  assign out_tlast  = o_rdata[2*TOK_W];

  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    d_nxt      = d_r;
    newest_nxt = newest_r;
    multi_nxt  = multi_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          c_nxt      = q_cmd.c0;
          n_nxt      = q_cmd.n;
          d_nxt      = IDX_W'(q_cmd.d);
          newest_nxt = q_cmd.newest;
          multi_nxt  = q_cmd.multi;
          if (q_cmd.has) begin
            state_nxt = S_CTR;
          end
        end
      end
      S_CTR: begin
        j_nxt     = j0;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        if (issue_ok) begin
          if (end_ctr) begin
            if (last_item) begin
              state_nxt = S_IDLE;
            end else begin
              c_nxt     = c_r - IDX_W'(1);
              state_nxt = S_CTR;
            end
          end else begin
            j_nxt = nj;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      rd_ctr_r <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= (state_r == S_CTR) || ((state_r == S_NBR) && issue_ok);
      rd_ctr_r  <= (state_r == S_CTR);
      rd_last_r <= (state_r == S_NBR) && last_item;
    end
  end

  always_ff @(posedge clk) begin
    c_r      <= c_nxt;
    j_r      <= j_nxt;
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    newest_r <= newest_nxt;
    multi_r  <= multi_nxt;
    if (rd_vld_r && rd_ctr_r) begin
      centre_r <= ram_rdata;
    end
  end

endmodule
`default_nettype wire

// File: sv/window_cooccurrence_pairs.sv
`default_nettype none
// channel  dir  handshake                     payload
// in       in   in_tvalid / in_tready         in_tdata {date, term_id}, in_tuser operation
// out      out  out_tvalid / out_tready       out_tdata {nbr date, nbr term, ctr date, ctr term},
//                                             out_tlast
// cfg      in   cfg_wr_en                     cfg_wr_data window
//
// A token holding its centre's pairs passes through the back end as one command pop, one centre read,
// then one pair per cycle from the single ring read port while the output queue has credit.
// End of sentence adds one centre read per pending centre.
// The front queues up to two commands, so input keeps flowing while pairs drain.
// Synchronous active-low reset clears counters, window (to 5) and queues; the ring needs none.
module window_cooccurrence_pairs
  import wcp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [WIN_W-1:0]   cfg_wr_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TOK_W-1:0]   in_tdata,    // [31:0] term_id, [63:32] date
  input  wire logic               in_tuser,    // [0] operation
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [2*TOK_W-1:0] out_tdata,   // [31:0] center_term, [63:32] center_date,
                                               // [95:64] neighbour_term, [127:96] neighbour_date
  output logic                    out_tlast
);

  localparam int QCW = $clog2(QDEPTH + 1);

  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  logic [QCW-1:0]   q_count;
  cmd_t             q_wcmd;
  logic [CMD_W-1:0] q_rdata;
  cmd_t             q_rcmd;

  assign q_rcmd = cmd_t'(q_rdata);
  assign q_full = (q_count == QCW'(QDEPTH));

  wcp_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_push      (q_push),
    .q_cmd       (q_wcmd),
    .q_full      (q_full)
  );

  wcp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  wcp_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_cmd      (q_rcmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
